[hdl/hrlq_pkg.sv]
// ----------------------------------------------------------------------------
// hrlq_pkg - shared types and constants of the heart-rate lock qualifier
// Register map, status structs, fixed thresholds and small helper functions.
// ----------------------------------------------------------------------------
package hrlq_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_WARMUP        = 3'd0,
		REG_RECOVERY_GAP  = 3'd1,
		REG_TRACK_LOST    = 3'd2,
		REG_ACQ_TIMEOUT   = 3'd3,
		REG_CONF_HARD     = 3'd4,
		REG_CONF_SOFT     = 3'd5,
		REG_MOTION_UP     = 3'd6,
		REG_MOTION_DOWN   = 3'd7
	} reg_idx_t;

	localparam int CFG_DATA_W = 17;

	typedef struct packed {
		logic [15:0] warmup_ms;
		logic [15:0] recovery_gap_ms;
		logic [16:0] track_lost_ms;
		logic [16:0] acquire_timeout_ms;
		logic [7:0]  conf_hard;
		logic [7:0]  conf_soft;
		logic [16:0] motion_up_thr;
		logic [16:0] motion_down_thr;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		warmup_ms:          16'd3000,
		recovery_gap_ms:    16'd8000,
		track_lost_ms:      17'd20000,
		acquire_timeout_ms: 17'd45000,
		conf_hard:          8'd85,
		conf_soft:          8'd60,
		motion_up_thr:      17'd420,
		motion_down_thr:    17'd220
	};

	typedef struct packed {
		logic publish;
		logic tracking;
		logic restart;
	} lock_res_t;

	typedef struct packed {
		logic scene;
		logic changed;
	} scene_res_t;

	// heart-rate windows (bpm)
	localparam logic signed [15:0] HR_MIN_BPM        = 16'sd40;
	localparam logic signed [15:0] HR_MAX_BPM        = 16'sd220;
	localparam logic signed [15:0] HR_ACQ_MIN_BPM    = 16'sd55;
	localparam logic signed [15:0] HR_ACQ_MAX_BPM    = 16'sd140;
	localparam logic signed [15:0] LOW_LOCK_BPM_MAX  = 16'sd45;
	localparam logic signed [15:0] HIGH_LOCK_BPM_MIN = 16'sd160;
	localparam logic signed [15:0] STUCK_LOW_BPM     = 16'sd42;

	// confidence thresholds
	localparam logic [7:0] CONF_LOCK          = 8'd78;
	localparam logic [7:0] CONF_TRACK_MIN     = 8'd60;
	localparam logic [7:0] CONF_LOCK_RELAX    = 8'd68;
	localparam logic [7:0] LOW_LOCK_CONF_MIN  = 8'd90;
	localparam logic [7:0] HIGH_LOCK_CONF_MAX = 8'd80;
	localparam logic [7:0] FAST_LOCK_CONF     = 8'd92;
	localparam logic [7:0] STUCK_CONF_MIN     = 8'd95;
	localparam logic [7:0] AGGR_LOCK_CONF     = 8'd72;

	// run lengths
	localparam logic [7:0] STABLE_N       = 8'd3;
	localparam logic [7:0] LOW_LOCK_HOLD  = 8'd8;
	localparam logic [7:0] HIGH_LOCK_HOLD = 8'd8;
	localparam logic [7:0] FAST_LOCK_N    = 8'd2;
	localparam logic [7:0] RELAX_LOCK_N   = 8'd4;
	localparam logic [7:0] NORMAL_LOCK_N  = 8'd4;
	localparam logic [7:0] STUCK_HOLD     = 8'd10;
	localparam logic [7:0] AGGR_LOCK_N    = 8'd2;
	localparam logic [7:0] SCENE_UP_N     = 8'd3;
	localparam logic [7:0] SCENE_DOWN_N   = 8'd5;

	// tolerances (bpm)
	localparam logic [3:0] STABLE_TOL = 4'd3;
	localparam logic [3:0] LOCK_TOL   = 4'd6;

	// times (ms)
	localparam logic [31:0] FAST_LOCK_MIN_MS  = 32'd1500;
	localparam logic [31:0] RELAX_LOCK_MIN_MS = 32'd6000;
	localparam logic [31:0] STUCK_MIN_MS      = 32'd15000;
	localparam logic [31:0] AGGR_WINDOW_MS    = 32'd12000;
	localparam logic [31:0] SCENE_PERIOD_MS   = 32'd1000;

	// L1 norm of the accelerometer at rest
	localparam logic [16:0] GRAVITY_L1 = 17'd2048;

	function automatic logic [7:0] sat_inc(input logic [7:0] c);
		return (c == 8'hFF) ? c : c + 8'd1;
	endfunction

	// |a - b| <= tol
	function automatic logic near(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic [3:0] tol);
		logic signed [16:0] d;
		logic signed [16:0] t;
		d = {a[15], a} - {b[15], b};
		t = $signed({13'd0, tol});
		return (d <= t) && (d >= -t);
	endfunction

endpackage

[hdl/hrlq_if.sv]
// ----------------------------------------------------------------------------
// hrlq_if - request channels of the heart-rate lock qualifier
// Sample channel (estimate, time, accelerometer) and result channel.
// ----------------------------------------------------------------------------
interface hrlq_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] hr_bpm;
	logic [7:0]         confidence;
	logic [31:0]        now_ms;
	logic               imu_valid;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;

	modport source (output valid, hr_bpm, confidence, now_ms, imu_valid,
		accel_x, accel_y, accel_z, input ready);
	modport sink (input valid, hr_bpm, confidence, now_ms, imu_valid,
		accel_x, accel_y, accel_z, output ready);
endinterface

interface hrlq_result_if;
	logic               valid;
	logic               ready;
	logic               publish;
	logic signed [15:0] out_hr_bpm;
	logic [7:0]         out_confidence;
	logic               tracking;
	logic               restart_request;
	logic               scene;
	logic               scene_changed;

	modport source (output valid, publish, out_hr_bpm, out_confidence, tracking,
		restart_request, scene, scene_changed, input ready);
	modport sink (input valid, publish, out_hr_bpm, out_confidence, tracking,
		restart_request, scene, scene_changed, output ready);
endinterface

[hdl/hrlq_lock.sv]
// ----------------------------------------------------------------------------
// hrlq_lock - acquire/track mode, stability runs and restart decisions
// State advances once per request when step is high.
// ----------------------------------------------------------------------------
module hrlq_lock (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic signed [15:0]        hr_bpm,
	input  logic [7:0]                confidence,
	input  logic [31:0]               now_ms,
	input  hrlq_pkg::cfg_t            cfg,
	output hrlq_pkg::lock_res_t       res
);

	logic               mode_q;
	logic [31:0]        start_q;
	logic [31:0]        last_valid_q;
	logic [31:0]        last_restart_q;
	logic [7:0]         stable_q;
	logic               cand_valid_q;
	logic signed [15:0] cand_hr_q;
	logic [7:0]         low_q;
	logic [7:0]         high_q;
	logic [7:0]         acq_low_q;

	logic               mode_n;
	logic [31:0]        start_n;
	logic [31:0]        last_valid_n;
	logic [31:0]        last_restart_n;
	logic [7:0]         stable_n;
	logic               cand_valid_n;
	logic signed [15:0] cand_hr_n;
	logic [7:0]         low_n;
	logic [7:0]         high_n;
	logic [7:0]         acq_low_n;
	logic               publish;
	logic               restart;

	always_comb begin
		logic [31:0] elapsed;
		logic        warm;
		logic        phys;
		logic        trk_ok;
		logic        in_acq;
		logic        acq_ok;
		logic        aggr;
		logic [7:0]  lock_conf;
		logic [7:0]  lock_n;
		logic        lock_c;
		logic        fast_c;
		logic        relax_c;
		logic        r_lock;
		logic        r_lost;
		logic        r_tmo;
		logic        r_stuck;

		elapsed     = now_ms - start_q;
		warm        = elapsed >= {16'd0, cfg.warmup_ms};
		phys        = (hr_bpm >= hrlq_pkg::HR_MIN_BPM) && (hr_bpm <= hrlq_pkg::HR_MAX_BPM);
		trk_ok      = phys && (confidence >= hrlq_pkg::CONF_TRACK_MIN);
		in_acq      = (hr_bpm >= hrlq_pkg::HR_ACQ_MIN_BPM) &&
			(hr_bpm <= hrlq_pkg::HR_ACQ_MAX_BPM);

		mode_n         = mode_q;
		start_n        = start_q;
		last_valid_n   = last_valid_q;
		last_restart_n = last_restart_q;
		stable_n       = stable_q;
		cand_valid_n   = cand_valid_q;
		cand_hr_n      = cand_hr_q;
		low_n          = low_q;
		high_n         = high_q;
		acq_low_n      = acq_low_q;
		restart        = 1'b0;
		r_lock         = 1'b0;
		r_lost         = 1'b0;
		r_tmo          = 1'b0;
		r_stuck        = 1'b0;

		// acquisition stage, 3 bpm run
		if (phys && (confidence >= cfg.conf_hard)) begin
			acq_ok = 1'b1;
		end else if (phys && (confidence >= cfg.conf_soft)) begin
			if (!cand_valid_n) begin
				stable_n     = 8'd1;
				cand_valid_n = 1'b1;
			end else if (hrlq_pkg::near(hr_bpm, cand_hr_n, hrlq_pkg::STABLE_TOL)) begin
				stable_n = hrlq_pkg::sat_inc(stable_n);
			end else begin
				stable_n = 8'd1;
			end
			cand_hr_n = hr_bpm;
			acq_ok    = stable_n >= hrlq_pkg::STABLE_N;
		end else begin
			acq_ok       = 1'b0;
			stable_n     = 8'd0;
			cand_valid_n = 1'b0;
		end

		// lock stage, 6 bpm run; early window uses the aggressive path
		aggr      = elapsed <= hrlq_pkg::AGGR_WINDOW_MS;
		lock_conf = aggr ? hrlq_pkg::AGGR_LOCK_CONF : hrlq_pkg::CONF_LOCK;
		lock_n    = aggr ? hrlq_pkg::AGGR_LOCK_N : hrlq_pkg::NORMAL_LOCK_N;
		lock_c    = warm && acq_ok && (confidence >= lock_conf) && in_acq;
		fast_c    = (elapsed >= hrlq_pkg::FAST_LOCK_MIN_MS) && acq_ok &&
			(confidence >= hrlq_pkg::FAST_LOCK_CONF) && in_acq;
		relax_c   = warm && (elapsed >= hrlq_pkg::RELAX_LOCK_MIN_MS) && trk_ok &&
			(confidence >= hrlq_pkg::CONF_LOCK_RELAX) && in_acq;

		if (lock_c) begin
			if (!cand_valid_n) begin
				stable_n     = 8'd1;
				cand_valid_n = 1'b1;
			end else if (hrlq_pkg::near(hr_bpm, cand_hr_n, hrlq_pkg::LOCK_TOL)) begin
				stable_n = hrlq_pkg::sat_inc(stable_n);
			end else begin
				stable_n = 8'd1;
			end
			cand_hr_n = hr_bpm;
			if (!mode_n && ((stable_n >= lock_n) ||
					(fast_c && (stable_n >= hrlq_pkg::FAST_LOCK_N)) ||
					(relax_c && (stable_n >= hrlq_pkg::RELAX_LOCK_N)))) begin
				mode_n       = 1'b1;
				last_valid_n = now_ms;
			end
		end else if (!mode_n) begin
			stable_n     = 8'd0;
			cand_valid_n = 1'b0;
		end

		publish = mode_n && trk_ok;

		if (!publish) begin
			low_n     = (warm && (hr_bpm <= hrlq_pkg::LOW_LOCK_BPM_MAX) &&
				(confidence >= hrlq_pkg::LOW_LOCK_CONF_MIN)) ? hrlq_pkg::sat_inc(low_q) : 8'd0;
			high_n    = (warm && (hr_bpm >= hrlq_pkg::HIGH_LOCK_BPM_MIN) &&
				(confidence <= hrlq_pkg::HIGH_LOCK_CONF_MAX)) ? hrlq_pkg::sat_inc(high_q) : 8'd0;
			acq_low_n = (!mode_n && warm && (hr_bpm <= hrlq_pkg::STUCK_LOW_BPM) &&
				(confidence >= hrlq_pkg::STUCK_CONF_MIN)) ? hrlq_pkg::sat_inc(acq_low_q) : 8'd0;

			r_lock  = mode_n && ((low_n >= hrlq_pkg::LOW_LOCK_HOLD) ||
				(high_n >= hrlq_pkg::HIGH_LOCK_HOLD));
			r_lost  = mode_n && warm &&
				((now_ms - last_valid_n) >= {15'd0, cfg.track_lost_ms});
			r_tmo   = !mode_n && (elapsed >= {15'd0, cfg.acquire_timeout_ms}) &&
				!(trk_ok && in_acq);
			r_stuck = !mode_n && warm && (elapsed >= hrlq_pkg::STUCK_MIN_MS) &&
				(acq_low_n >= hrlq_pkg::STUCK_HOLD);

			if (warm && (r_lock || r_lost || r_tmo || r_stuck) &&
					((now_ms - last_restart_q) >= {16'd0, cfg.recovery_gap_ms})) begin
				restart        = 1'b1;
				start_n        = now_ms;
				mode_n         = 1'b0;
				stable_n       = 8'd0;
				cand_valid_n   = 1'b0;
				low_n          = 8'd0;
				high_n         = 8'd0;
				acq_low_n      = 8'd0;
				last_valid_n   = now_ms;
				last_restart_n = now_ms;
			end
		end else begin
			low_n        = 8'd0;
			high_n       = 8'd0;
			last_valid_n = now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			start_q        <= '0;
			last_valid_q   <= '0;
			last_restart_q <= '0;
			stable_q       <= '0;
			cand_valid_q   <= 1'b0;
			cand_hr_q      <= '0;
			low_q          <= '0;
			high_q         <= '0;
			acq_low_q      <= '0;
		end else if (step) begin
			mode_q         <= mode_n;
			start_q        <= start_n;
			last_valid_q   <= last_valid_n;
			last_restart_q <= last_restart_n;
			stable_q       <= stable_n;
			cand_valid_q   <= cand_valid_n;
			cand_hr_q      <= cand_hr_n;
			low_q          <= low_n;
			high_q         <= high_n;
			acq_low_q      <= acq_low_n;
		end
	end

	assign res.publish  = publish;
	assign res.tracking = mode_n;
	assign res.restart  = restart;

endmodule

[hdl/hrlq_scene.sv]
// ----------------------------------------------------------------------------
// hrlq_scene - once-per-second motion scene hysteresis
// Rest/daily decision from the accelerometer L1 norm minus gravity.
// ----------------------------------------------------------------------------
module hrlq_scene (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       restart,
	input  logic [31:0]                now_ms,
	input  logic                       imu_valid,
	input  logic signed [15:0]         accel_x,
	input  logic signed [15:0]         accel_y,
	input  logic signed [15:0]         accel_z,
	input  hrlq_pkg::cfg_t             cfg,
	output hrlq_pkg::scene_res_t       res
);

	logic [31:0] last_scene_q;
	logic [7:0]  up_q;
	logic [7:0]  down_q;
	logic        scene_q;

	logic [31:0] last_scene_n;
	logic [7:0]  up_n;
	logic [7:0]  down_n;
	logic        scene_n;
	logic        changed;

	function automatic logic [16:0] mag(input logic signed [15:0] v);
		return v[15] ? 17'(-{v[15], v}) : {1'b0, v};
	endfunction

	always_comb begin
		logic        due;
		logic [16:0] l1;
		logic [16:0] motion;

		due    = (now_ms - last_scene_q) >= hrlq_pkg::SCENE_PERIOD_MS;
		l1     = mag(accel_x) + mag(accel_y) + mag(accel_z);
		motion = (l1 >= hrlq_pkg::GRAVITY_L1) ? l1 - hrlq_pkg::GRAVITY_L1
			: hrlq_pkg::GRAVITY_L1 - l1;

		up_n    = up_q;
		down_n  = down_q;
		scene_n = scene_q;
		changed = 1'b0;

		if (due && imu_valid) begin
			if (motion >= cfg.motion_up_thr) begin
				up_n   = hrlq_pkg::sat_inc(up_q);
				down_n = 8'd0;
			end else if (motion <= cfg.motion_down_thr) begin
				down_n = hrlq_pkg::sat_inc(down_q);
				up_n   = 8'd0;
			end else begin
				up_n   = 8'd0;
				down_n = 8'd0;
			end
			if (!scene_q && (up_n >= hrlq_pkg::SCENE_UP_N)) begin
				scene_n = 1'b1;
				up_n    = 8'd0;
				changed = 1'b1;
			end else if (scene_q && (down_n >= hrlq_pkg::SCENE_DOWN_N)) begin
				scene_n = 1'b0;
				down_n  = 8'd0;
				changed = 1'b1;
			end
		end

		// a restart also restarts the evaluation period
		last_scene_n = (due || restart) ? now_ms : last_scene_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_scene_q <= '0;
			up_q         <= '0;
			down_q       <= '0;
			scene_q      <= 1'b0;
		end else if (step) begin
			last_scene_q <= last_scene_n;
			up_q         <= up_n;
			down_q       <= down_n;
			scene_q      <= scene_n;
		end
	end

	assign res.scene   = scene_n;
	assign res.changed = changed;

endmodule

[hdl/heart_rate_lock_qualifier.sv]
// ----------------------------------------------------------------------------
// heart_rate_lock_qualifier - publish qualification of heart-rate estimates
// Input register, single-pass lock and scene logic, result register.
// ----------------------------------------------------------------------------
// Usage
//   sample : one request per heart-rate estimate (bpm, confidence, ms
//            timestamp, optional accelerometer reading).
//   result : one request per sample, in order: publish flag, estimate and
//            confidence passed through, track mode, restart request, scene
//            and scene-change flag.
//   cfg_*  : write-only register port, index = register number, taken on any
//            clock with cfg_we high; only write while the block is empty.
// Timing
//   The sample is loaded into the input register at acceptance, then the
//   lock/scene pass loads the result register and raises result valid.
//   Throughput one sample per cycle while result.ready is high; all per-sample
//   work is compare-and-count logic between the two registers.
// Reset
//   arst_n clears mode (acquire), timers, counters, scene (still rest) and
//   loads the default register values. No clearing pass.
// Back-pressure
//   While result.ready is low the held result stays put and one further
//   sample waits in the input register; sample.ready then drops.
// ----------------------------------------------------------------------------
module heart_rate_lock_qualifier (
	input  logic                              clk,
	input  logic                              arst_n,
	hrlq_sample_if.sink                       sample,
	hrlq_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [hrlq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	// configuration registers
	hrlq_pkg::cfg_t cfg_q;

	// input register stage
	logic               valid_s1;
	logic signed [15:0] hr_bpm_s1;
	logic [7:0]         confidence_s1;
	logic [31:0]        now_ms_s1;
	logic               imu_valid_s1;
	logic signed [15:0] accel_x_s1;
	logic signed [15:0] accel_y_s1;
	logic signed [15:0] accel_z_s1;

	// result register
	logic               res_valid_q;
	logic               publish_q;
	logic signed [15:0] hr_bpm_q;
	logic [7:0]         confidence_q;
	logic               tracking_q;
	logic               restart_q;
	logic               scene_q;
	logic               scene_changed_q;

	logic                  advance;
	hrlq_pkg::lock_res_t   lock_res;
	hrlq_pkg::scene_res_t  scene_res;

	// The stage-1 sample is processed when the result register is free or
	// being emptied this cycle; stage 1 refills in the same cycle.
	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	// register writes; upper data bits beyond a register's width are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hrlq_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (hrlq_pkg::reg_idx_t'(cfg_index))
				hrlq_pkg::REG_WARMUP:       cfg_q.warmup_ms          <= cfg_wdata[15:0];
				hrlq_pkg::REG_RECOVERY_GAP: cfg_q.recovery_gap_ms    <= cfg_wdata[15:0];
				hrlq_pkg::REG_TRACK_LOST:   cfg_q.track_lost_ms      <= cfg_wdata[16:0];
				hrlq_pkg::REG_ACQ_TIMEOUT:  cfg_q.acquire_timeout_ms <= cfg_wdata[16:0];
				hrlq_pkg::REG_CONF_HARD:    cfg_q.conf_hard          <= cfg_wdata[7:0];
				hrlq_pkg::REG_CONF_SOFT:    cfg_q.conf_soft          <= cfg_wdata[7:0];
				hrlq_pkg::REG_MOTION_UP:    cfg_q.motion_up_thr      <= cfg_wdata[16:0];
				hrlq_pkg::REG_MOTION_DOWN:  cfg_q.motion_down_thr    <= cfg_wdata[16:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1: capture the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			hr_bpm_s1     <= sample.hr_bpm;
			confidence_s1 <= sample.confidence;
			now_ms_s1     <= sample.now_ms;
			imu_valid_s1  <= sample.imu_valid;
			accel_x_s1    <= sample.accel_x;
			accel_y_s1    <= sample.accel_y;
			accel_z_s1    <= sample.accel_z;
		end
	end

	// lock qualification: mode, stability runs, restart decision
	hrlq_lock u_lock (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.hr_bpm     (hr_bpm_s1),
		.confidence (confidence_s1),
		.now_ms     (now_ms_s1),
		.cfg        (cfg_q),
		.res        (lock_res)
	);

	// motion scene; a restart re-bases its evaluation period
	hrlq_scene u_scene (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.restart   (lock_res.restart),
		.now_ms    (now_ms_s1),
		.imu_valid (imu_valid_s1),
		.accel_x   (accel_x_s1),
		.accel_y   (accel_y_s1),
		.accel_z   (accel_z_s1),
		.cfg       (cfg_q),
		.res       (scene_res)
	);

	// stage 2: result register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			publish_q       <= lock_res.publish;
			hr_bpm_q        <= hr_bpm_s1;
			confidence_q    <= confidence_s1;
			tracking_q      <= lock_res.tracking;
			restart_q       <= lock_res.restart;
			scene_q         <= scene_res.scene;
			scene_changed_q <= scene_res.changed;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.publish         = publish_q;
	assign result.out_hr_bpm      = hr_bpm_q;
	assign result.out_confidence  = confidence_q;
	assign result.tracking        = tracking_q;
	assign result.restart_request = restart_q;
	assign result.scene           = scene_q;
	assign result.scene_changed   = scene_changed_q;

endmodule

[test/heart_rate_lock_qualifier_tb.sv]
// ----------------------------------------------------------------------------
// heart_rate_lock_qualifier_tb - self-checking bench of the lock qualifier
// A behavioural predictor runs alongside the block. Each accepted sample
// request is scored by the predictor and the verdict is queued. Each result
// request is then compared field by field with the oldest queued verdict.
// A directed opening is followed by randomised episodes: steady runs, stuck
// low, stuck high, dropouts, noise and time jumps. These run under the reset,
// all-zero, all-ones and mixed register settings, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module heart_rate_lock_qualifier_tb;

	localparam int CYCLE_LIMIT = 400_000;

	// one estimate as offered on the sample channel
	typedef struct packed {
		logic signed [15:0] hr_bpm;
		logic [7:0]         confidence;
		logic [31:0]        now_ms;
		logic               imu_valid;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} sample_t;

	// what the result channel should carry for one sample
	typedef struct packed {
		logic               publish;
		logic signed [15:0] hr_bpm;
		logic [7:0]         confidence;
		logic               tracking;
		logic               restart;
		logic               scene;
		logic               scene_changed;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [hrlq_pkg::CFG_DATA_W-1:0] cfg_wdata;

	hrlq_sample_if smp ();
	hrlq_result_if res ();

	heart_rate_lock_qualifier uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor state: shadow of the registers plus the lock/scene state
	// ------------------------------------------------------------------
	hrlq_pkg::cfg_t cfg_shadow = hrlq_pkg::CFG_RESET;
	logic        mode_track = 1'b0;
	logic [31:0] t_start = '0;
	logic [31:0] t_last_valid = '0;
	logic [31:0] t_last_restart = '0;
	logic [31:0] t_last_scene = '0;
	logic [7:0]  run_len = '0;
	logic        cand_held = 1'b0;
	int          cand_bpm = 0;
	logic [7:0]  low_hold = '0;
	logic [7:0]  high_hold = '0;
	logic [7:0]  stuck_hold = '0;
	logic        scene_daily = 1'b0;
	logic [7:0]  up_votes = '0;
	logic [7:0]  down_votes = '0;

	verdict_t awaited_verdicts [$];
	verdict_t oldest;
	int       mismatches = 0;

	// stimulus bookkeeping
	logic [31:0] wall_ms = '0;
	int          activity = 0;
	int          src_calm = 0;
	int          sink_calm = 0;

	function automatic int spread(input int lo, input int hi);
		return lo + int'($urandom_range(32'(hi - lo), 0));
	endfunction

	function automatic int magnitude(input int x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic logic [7:0] bump(input logic [7:0] c);
		return (c == 8'hFF) ? c : c + 8'd1;
	endfunction

	function automatic logic [31:0] since_ms(input logic [31:0] now, input logic [31:0] stamp);
		return now - stamp;
	endfunction

	// candidate run: first sample opens a run, a close one extends it
	function automatic void follow_candidate(input int bpm, input int tol);
		if (!cand_held) begin
			run_len = 8'd1;
			cand_held = 1'b1;
		end else if (magnitude(bpm - cand_bpm) <= tol) begin
			run_len = bump(run_len);
		end else begin
			run_len = 8'd1;
		end
		cand_bpm = bpm;
	endfunction

	// One step of the qualifier. Time arithmetic is modulo 2^32 throughout,
	// so a timestamp that steps back reads as a very long elapsed time.
	function automatic verdict_t qualify_estimate(input sample_t s);
		int hr, conf, motion, lock_conf;
		logic [31:0] elapsed;
		logic [7:0] lock_n;
		logic warm, phys, trk_ok, in_acq, acq_ok, aggr;
		logic lock_c, fast_c, relax_c, published, restarted, flipped;
		logic r_lock, r_lost, r_tmo, r_stuck;
		verdict_t v;

		hr = int'(s.hr_bpm);
		conf = int'(s.confidence);
		elapsed = since_ms(s.now_ms, t_start);
		warm = elapsed >= 32'(cfg_shadow.warmup_ms);
		flipped = 1'b0;
		restarted = 1'b0;

		// scene vote once a second; no accelerometer data still takes the slot
		if (since_ms(s.now_ms, t_last_scene) >= hrlq_pkg::SCENE_PERIOD_MS) begin
			if (s.imu_valid) begin
				motion = magnitude(magnitude(int'(s.accel_x)) + magnitude(int'(s.accel_y))
					+ magnitude(int'(s.accel_z)) - int'(hrlq_pkg::GRAVITY_L1));
				if (motion >= int'(cfg_shadow.motion_up_thr)) begin
					up_votes = bump(up_votes);
					down_votes = 8'd0;
				end else if (motion <= int'(cfg_shadow.motion_down_thr)) begin
					down_votes = bump(down_votes);
					up_votes = 8'd0;
				end else begin
					up_votes = 8'd0;
					down_votes = 8'd0;
				end
				if (!scene_daily && up_votes >= hrlq_pkg::SCENE_UP_N) begin
					scene_daily = 1'b1;
					up_votes = 8'd0;
					flipped = 1'b1;
				end else if (scene_daily && down_votes >= hrlq_pkg::SCENE_DOWN_N) begin
					scene_daily = 1'b0;
					down_votes = 8'd0;
					flipped = 1'b1;
				end
			end
			t_last_scene = s.now_ms;
		end

		phys = hr >= int'(hrlq_pkg::HR_MIN_BPM) && hr <= int'(hrlq_pkg::HR_MAX_BPM);
		trk_ok = phys && conf >= int'(hrlq_pkg::CONF_TRACK_MIN);
		in_acq = hr >= int'(hrlq_pkg::HR_ACQ_MIN_BPM) && hr <= int'(hrlq_pkg::HR_ACQ_MAX_BPM);

		// acquisition stage: hard confidence at once, soft needs a run
		if (phys && conf >= int'(cfg_shadow.conf_hard)) begin
			acq_ok = 1'b1;
		end else if (phys && conf >= int'(cfg_shadow.conf_soft)) begin
			follow_candidate(hr, int'(hrlq_pkg::STABLE_TOL));
			acq_ok = run_len >= hrlq_pkg::STABLE_N;
		end else begin
			acq_ok = 1'b0;
			run_len = 8'd0;
			cand_held = 1'b0;
		end

		// lock stage; a soft-stage sample may advance the run a second time here
		aggr = elapsed <= hrlq_pkg::AGGR_WINDOW_MS;
		lock_conf = aggr ? int'(hrlq_pkg::AGGR_LOCK_CONF) : int'(hrlq_pkg::CONF_LOCK);
		lock_n = aggr ? hrlq_pkg::AGGR_LOCK_N : hrlq_pkg::NORMAL_LOCK_N;
		lock_c = warm && acq_ok && conf >= lock_conf && in_acq;
		fast_c = elapsed >= hrlq_pkg::FAST_LOCK_MIN_MS && acq_ok
			&& conf >= int'(hrlq_pkg::FAST_LOCK_CONF) && in_acq;
		relax_c = warm && elapsed >= hrlq_pkg::RELAX_LOCK_MIN_MS && trk_ok
			&& conf >= int'(hrlq_pkg::CONF_LOCK_RELAX) && in_acq;

		if (lock_c) begin
			follow_candidate(hr, int'(hrlq_pkg::LOCK_TOL));
			if (!mode_track && (run_len >= lock_n
					|| (fast_c && run_len >= hrlq_pkg::FAST_LOCK_N)
					|| (relax_c && run_len >= hrlq_pkg::RELAX_LOCK_N))) begin
				mode_track = 1'b1;
				t_last_valid = s.now_ms;
			end
		end else if (!mode_track) begin
			run_len = 8'd0;
			cand_held = 1'b0;
		end

		if (mode_track && trk_ok)
			t_last_valid = s.now_ms;

		published = mode_track && trk_ok;
		if (!published) begin
			low_hold = (warm && hr <= int'(hrlq_pkg::LOW_LOCK_BPM_MAX)
				&& conf >= int'(hrlq_pkg::LOW_LOCK_CONF_MIN)) ? bump(low_hold) : 8'd0;
			high_hold = (warm && hr >= int'(hrlq_pkg::HIGH_LOCK_BPM_MIN)
				&& conf <= int'(hrlq_pkg::HIGH_LOCK_CONF_MAX)) ? bump(high_hold) : 8'd0;
			stuck_hold = (!mode_track && warm && hr <= int'(hrlq_pkg::STUCK_LOW_BPM)
				&& conf >= int'(hrlq_pkg::STUCK_CONF_MIN)) ? bump(stuck_hold) : 8'd0;

			r_lock = mode_track && (low_hold >= hrlq_pkg::LOW_LOCK_HOLD
				|| high_hold >= hrlq_pkg::HIGH_LOCK_HOLD);
			r_lost = mode_track && warm
				&& since_ms(s.now_ms, t_last_valid) >= 32'(cfg_shadow.track_lost_ms);
			r_tmo = !mode_track && elapsed >= 32'(cfg_shadow.acquire_timeout_ms)
				&& !(trk_ok && in_acq);
			r_stuck = !mode_track && warm && elapsed >= hrlq_pkg::STUCK_MIN_MS
				&& stuck_hold >= hrlq_pkg::STUCK_HOLD;

			// restart is rate limited and taken to succeed at once
			if (warm && (r_lock || r_lost || r_tmo || r_stuck)
					&& since_ms(s.now_ms, t_last_restart) >= 32'(cfg_shadow.recovery_gap_ms)) begin
				restarted = 1'b1;
				t_start = s.now_ms;
				mode_track = 1'b0;
				run_len = 8'd0;
				cand_held = 1'b0;
				low_hold = 8'd0;
				high_hold = 8'd0;
				stuck_hold = 8'd0;
				t_last_valid = s.now_ms;
				t_last_restart = s.now_ms;
				t_last_scene = s.now_ms;
			end
		end else begin
			low_hold = 8'd0;
			high_hold = 8'd0;
			t_last_valid = s.now_ms;
		end

		v.publish = published;
		v.hr_bpm = s.hr_bpm;
		v.confidence = s.confidence;
		v.tracking = mode_track;
		v.restart = restarted;
		v.scene = scene_daily;
		v.scene_changed = flipped;
		return v;
	endfunction

	// ------------------------------------------------------------------
	// monitors: score each accepted sample, check each accepted result
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (smp.valid === 1'b1 && smp.ready === 1'b1)
			awaited_verdicts.push_back(qualify_estimate({smp.hr_bpm, smp.confidence,
				smp.now_ms, smp.imu_valid, smp.accel_x, smp.accel_y, smp.accel_z}));
	end

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			if (awaited_verdicts.size() == 0) begin
				mismatches++;
				$display("%0t: result request with none pending, expected none actual hr %0h",
					$time, res.out_hr_bpm);
			end else begin
				oldest = awaited_verdicts.pop_front();
				check_field("publish", 32'(oldest.publish), 32'(res.publish));
				check_field("out_hr_bpm", 32'(oldest.hr_bpm), 32'(res.out_hr_bpm));
				check_field("out_confidence", 32'(oldest.confidence), 32'(res.out_confidence));
				check_field("tracking", 32'(oldest.tracking), 32'(res.tracking));
				check_field("restart_request", 32'(oldest.restart), 32'(res.restart_request));
				check_field("scene", 32'(oldest.scene), 32'(res.scene));
				check_field("scene_changed", 32'(oldest.scene_changed), 32'(res.scene_changed));
			end
		end
	end

	// idle draw per request; now and then a calm stretch with no idling at all
	function automatic int idle_cycles(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(24, 0) == 0) begin
			calm = spread(8, 40);
			return 0;
		end
		return spread(0, 16);
	endfunction

	// result side: stall a drawn number of cycles before each request
	initial begin
		int gap;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idle_cycles(sink_calm);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (res.valid !== 1'b1);
		end
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic sample_t mk(input int hr, input int conf, input logic [31:0] now,
			input logic imu, input int ax, input int ay, input int az);
		sample_t s;
		s.hr_bpm = 16'(hr);
		s.confidence = 8'(conf);
		s.now_ms = now;
		s.imu_valid = imu;
		s.accel_x = 16'(ax);
		s.accel_y = 16'(ay);
		s.accel_z = 16'(az);
		return s;
	endfunction

	// offer one sample request; valid stays high on return so a back-to-back
	// request never sees valid dropped and raised in the same step
	task automatic send_sample(input sample_t s);
		int gap;
		gap = idle_cycles(src_calm);
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.hr_bpm <= s.hr_bpm;
		smp.confidence <= s.confidence;
		smp.now_ms <= s.now_ms;
		smp.imu_valid <= s.imu_valid;
		smp.accel_x <= s.accel_x;
		smp.accel_y <= s.accel_y;
		smp.accel_z <= s.accel_z;
		do @(posedge clk); while (smp.ready !== 1'b1);
	endtask

	// advance the wall clock and send with accelerometer data of the current activity
	task automatic feed(input int hr, input int conf, input int advance_ms);
		int ax, ay, az;
		logic imu;
		wall_ms = wall_ms + 32'(advance_ms);
		imu = spread(0, 9) != 0;
		case (activity)
			0: begin
				// wrist at rest
				ax = spread(-60, 60);
				ay = spread(-60, 60);
				az = 2048 + spread(-60, 60);
			end
			1: begin
				ax = spread(-1500, 1500);
				ay = spread(-1500, 1500);
				az = 2048 + spread(600, 4000);
			end
			2: begin
				// motion around the two reset thresholds
				ax = spread(-100, 100);
				ay = 0;
				az = 2048 + spread(150, 450);
			end
			default: begin
				ax = int'($urandom());
				ay = int'($urandom());
				az = int'($urandom());
			end
		endcase
		if (spread(0, 3) == 0)
			az = -az;
		send_sample(mk(hr, conf, wall_ms, imu, ax, ay, az));
	endtask

	// drain: wait until every pending verdict is answered, then idle to let the pipe empty
	task automatic quiesce();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (awaited_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_reg(input hrlq_pkg::reg_idx_t idx,
			input logic [hrlq_pkg::CFG_DATA_W-1:0] raw);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= raw;
		// shadow keeps only the register's own width
		case (idx)
			hrlq_pkg::REG_WARMUP:       cfg_shadow.warmup_ms = raw[15:0];
			hrlq_pkg::REG_RECOVERY_GAP: cfg_shadow.recovery_gap_ms = raw[15:0];
			hrlq_pkg::REG_TRACK_LOST:   cfg_shadow.track_lost_ms = raw;
			hrlq_pkg::REG_ACQ_TIMEOUT:  cfg_shadow.acquire_timeout_ms = raw;
			hrlq_pkg::REG_CONF_HARD:    cfg_shadow.conf_hard = raw[7:0];
			hrlq_pkg::REG_CONF_SOFT:    cfg_shadow.conf_soft = raw[7:0];
			hrlq_pkg::REG_MOTION_UP:    cfg_shadow.motion_up_thr = raw;
			hrlq_pkg::REG_MOTION_DOWN:  cfg_shadow.motion_down_thr = raw;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [16:0] warmup, input logic [16:0] gap,
			input logic [16:0] lost, input logic [16:0] tmo, input logic [16:0] hard_thr,
			input logic [16:0] soft_thr, input logic [16:0] up, input logic [16:0] down);
		quiesce();
		program_reg(hrlq_pkg::REG_WARMUP, warmup);
		program_reg(hrlq_pkg::REG_RECOVERY_GAP, gap);
		program_reg(hrlq_pkg::REG_TRACK_LOST, lost);
		program_reg(hrlq_pkg::REG_ACQ_TIMEOUT, tmo);
		program_reg(hrlq_pkg::REG_CONF_HARD, hard_thr);
		program_reg(hrlq_pkg::REG_CONF_SOFT, soft_thr);
		program_reg(hrlq_pkg::REG_MOTION_UP, up);
		program_reg(hrlq_pkg::REG_MOTION_DOWN, down);
		cfg_we <= 1'b0;
	endtask

	// Random episodes. Half of the twelve kinds are steady runs aimed at lock and
	// tracking; the rest drive the recovery paths, noise and time jumps.
	task automatic run_episodes(input int budget);
		int sent, kind, len, centre, jitter, conf_lo, conf_hi, adv_lo, adv_hi, k, hr, conf;
		logic wild;
		sent = 0;
		while (sent < budget) begin
			kind = spread(0, 11);
			activity = spread(0, 3);
			wild = 1'b0;
			centre = spread(55, 140);
			jitter = 3;
			conf_lo = 60;
			conf_hi = 100;
			adv_lo = 300;
			adv_hi = 1500;
			len = spread(4, 20);
			case (kind)
				5: begin
					// stuck low
					centre = spread(30, 45);
					jitter = 2;
					conf_lo = 88;
					len = spread(8, 14);
				end
				6: begin
					// stuck high with weak confidence
					centre = spread(160, 220);
					jitter = 5;
					conf_lo = 55;
					conf_hi = 80;
					len = spread(8, 12);
				end
				7: begin
					// dropout, at times long enough to lose tracking or time out
					jitter = 20;
					conf_lo = 0;
					conf_hi = 59;
					adv_lo = 1000;
					adv_hi = 5000;
					len = spread(3, 15);
				end
				8: begin
					wild = 1'b1;
					len = spread(1, 4);
				end
				9: begin
					adv_lo = 8000;
					adv_hi = 60000;
					len = spread(1, 2);
				end
				10: begin
					// clock steps back or lands anywhere in the 32-bit range
					if (spread(0, 1) == 0)
						wall_ms = $urandom();
					else
						wall_ms = wall_ms - 32'(spread(1, 5000));
					len = spread(2, 6);
				end
				11: begin
					// soft confidence band
					conf_lo = 60;
					conf_hi = 84;
					len = spread(5, 12);
				end
				default: begin
					if (spread(0, 4) == 0)
						centre = spread(40, 220);
					jitter = (spread(0, 3) == 0) ? 8 : spread(0, 3);
					conf_lo = spread(55, 92);
					conf_hi = conf_lo + spread(0, 10);
				end
			endcase
			for (k = 0; k < len; k++) begin
				if (wild) begin
					hr = int'($urandom());
					conf = spread(0, 255);
					if (spread(0, 2) == 0)
						wall_ms = $urandom();
					feed(hr, conf, spread(0, 3000));
				end else begin
					hr = centre + spread(-jitter, jitter);
					conf = spread(conf_lo, (conf_hi > 255) ? 255 : conf_hi);
					feed(hr, conf, spread(adv_lo, adv_hi));
				end
			end
			sent += len;
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// field extremes, scene switch, aggressive lock, publish, stuck-low restart,
	// time going backwards and the top of the time range
	task automatic test_directed();
		int k;
		send_sample(mk(72, 0, 0, 1'b0, 0, 0, 0));
		send_sample(mk(-32768, 255, 500, 1'b1, -32768, -32768, -32768));
		send_sample(mk(32767, 255, 1000, 1'b1, 32767, 32767, 32767));
		send_sample(mk(40, 60, 2000, 1'b1, 3000, -3000, 2048));
		send_sample(mk(220, 84, 3000, 1'b1, 0, 0, 6000));
		send_sample(mk(221, 85, 3500, 1'b0, 0, 0, 0));
		// scene slot with no accelerometer data
		send_sample(mk(39, 99, 4000, 1'b0, 5000, 5000, 5000));
		send_sample(mk(70, 90, 4500, 1'b1, 0, 0, 2048));
		send_sample(mk(71, 90, 5000, 1'b1, 0, 0, 2048));
		send_sample(mk(75, 60, 5500, 1'b1, 0, 0, 2048));
		send_sample(mk(70, 59, 6000, 1'b1, 0, 0, 2048));
		// stuck low while tracking: hold of eight then restart
		for (k = 0; k < 8; k++)
			send_sample(mk(30, 95, 32'(6500 + 500 * k), 1'b1, 10, -10, 2040));
		// timestamp behind the restart time: elapsed reads huge
		send_sample(mk(100, 255, 5, 1'b1, -1, -1, -1));
		send_sample(mk(82, 80, 32'hFFFF_FFFF, 1'b1, 0, 0, -2048));
		send_sample(mk(80, 80, 32'h0000_0400, 1'b0, 0, 0, 0));
		wall_ms = 32'h0000_0400;
	endtask

	task automatic test_reset_settings();
		run_episodes(350);
	endtask

	// everything zero; upper bits set to show they are dropped
	task automatic test_zero_settings();
		load_settings(17'h10000, 17'h10000, 17'd0, 17'd0, 17'h1FF00, 17'h1FF00, 17'd0, 17'd0);
		run_episodes(150);
	endtask

	task automatic test_full_settings();
		load_settings(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
			17'h1FFFF, 17'h1FFFF);
		run_episodes(150);
	endtask

	task automatic test_mixed_settings();
		int round;
		for (round = 0; round < 3; round++) begin
			load_settings(17'(spread(0, 6000)), 17'(spread(0, 20000)), 17'(spread(2000, 40000)),
				17'(spread(5000, 70000)),
				17'(spread(60, 100)) | (17'($urandom()) & 17'h1FF00),
				17'(spread(30, 85)) | (17'($urandom()) & 17'h1FF00),
				17'(spread(100, 1000)), 17'(spread(50, 400)));
			run_episodes(100);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= hrlq_pkg::REG_WARMUP;
		cfg_wdata <= '0;
		smp.valid <= 1'b0;
		smp.hr_bpm <= '0;
		smp.confidence <= '0;
		smp.now_ms <= '0;
		smp.imu_valid <= 1'b0;
		smp.accel_x <= '0;
		smp.accel_y <= '0;
		smp.accel_z <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_reset_settings();
		test_zero_settings();
		test_full_settings();
		test_mixed_settings();

		// all requests answered, then a margin for stray results
		quiesce();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaited_verdicts.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
hdl/hrlq_pkg.sv
hdl/hrlq_if.sv
hdl/hrlq_lock.sv
hdl/hrlq_scene.sv
hdl/heart_rate_lock_qualifier.sv
test/heart_rate_lock_qualifier_tb.sv
